// ===== rtl/core/ple_pkg.sv =====
package ple_pkg;

  localparam int REQ_W  = 3;
  localparam int DATA_W = 32;
  localparam int POS_W  = 7;
  localparam int STAT_W = 3;

  localparam logic [REQ_W-1:0] REQ_INS_HEAD = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_TAIL = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_AT   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_AT   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SEARCH   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_RD_FWD   = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RD_BWD   = 3'd6;
  localparam logic [REQ_W-1:0] REQ_COUNT    = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE     = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

  localparam logic [1:0] OSEL_RES  = 2'd0;
  localparam logic [1:0] OSEL_ELEM = 2'd1;
  localparam logic [1:0] OSEL_PEND = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] item_value;
    logic [POS_W-1:0]         list_position;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] out_value;
    logic [POS_W-1:0]         out_position;
    logic [POS_W-1:0]         element_total;
    logic                     last_of_run;
  } rsp_t;

  typedef struct packed {
    logic              take;
    logic              clear;
    logic              load_head;
    logic              adv_fwd;
    logic              adv_bwd;
    logic              idx_inc;
    logic              idx_dec;
    logic              idx_to_count;
    logic              wr_single;
    logic              wr_ins1;
    logic              wr_ins2;
    logic              wr_del;
    logic              pend_set;
    logic              out_load;
    logic [1:0]        out_sel;
    logic [STAT_W-1:0] out_status;
    logic              out_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             clr_last;
    logic             empty;
    logic             ins_bad;
    logic             ins_full;
    logic             ins_to_head;
    logic             ins_at_end;
    logic             del_bad;
    logic             del_first;
    logic             walk_last;
    logic             idx_is_one;
    logic             idx_is_count;
    logic             match;
    logic             pend_valid;
    logic             out_free;
  } ctl_stat_t;

endpackage

// ===== rtl/core/positional_list_engine.sv =====
// Steps: insert at head or tail and delete at position 1 link the slot with no walk;
// insert or delete at position p first walks p-1 links, one list link per cycle;
// read-out and search walk all elements, one per cycle unless a stalled result holds them.
// Throughput: one request at a time; read-out gives one result per cycle unless stalled.
// The link walk through the registered-read slot memories sets each request's length.
// Reset (rst, synchronous): empties the list, then sweeps all LIST_CAPACITY slots of the
// free-slot pool, during which no request is accepted.
module positional_list_engine #(
  parameter int LIST_CAPACITY = 64,
  parameter int VALUE_BITS    = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ple_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ple_pkg::rsp_t rsp_data
);

  ple_pkg::ctl_cmd_t  cmd;
  ple_pkg::ctl_stat_t st;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  ple_dpath #(
    .LIST_CAPACITY (LIST_CAPACITY),
    .VALUE_BITS    (VALUE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cmd       (cmd),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

// ===== rtl/core/ple_ram.sv =====
module ple_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ple_ctrl.sv =====
module ple_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  ple_pkg::ctl_stat_t st,
  output ple_pkg::ctl_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HEAD   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_WALK   = 4'd4;
  localparam logic [3:0] S_INS1   = 4'd5;
  localparam logic [3:0] S_INS2   = 4'd6;
  localparam logic [3:0] S_DEL    = 4'd7;
  localparam logic [3:0] S_SCAN   = 4'd8;
  localparam logic [3:0] S_SFIN   = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  logic [3:0]                  state, state_next;
  logic [ple_pkg::STAT_W-1:0]  code, code_next;
  logic                        back, scan_last;

  assign req_stall = (state != S_IDLE);
  assign back      = (st.req == ple_pkg::REQ_RD_BWD);
  assign scan_last = back ? st.idx_is_one : st.idx_is_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      code  <= ple_pkg::ST_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    code_next  = code;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.load_head = 1'b1;
        state_next    = S_DECIDE;
      end
      S_DECIDE: begin
        code_next  = ple_pkg::ST_OK;
        state_next = S_EMIT;
        unique case (st.req) inside
          ple_pkg::REQ_INS_HEAD, ple_pkg::REQ_INS_TAIL, ple_pkg::REQ_INS_AT: begin
            if (st.ins_bad) begin
              code_next = ple_pkg::ST_RANGE;
            end else if (st.ins_full) begin
              code_next = ple_pkg::ST_FULL;
            end else if (st.empty) begin
              cmd.wr_single = 1'b1;
            end else if (st.ins_to_head || st.ins_at_end) begin
              state_next = S_INS1;
            end else begin
              state_next = S_WALK;
            end
          end
          ple_pkg::REQ_DEL_AT: begin
            if (st.empty) begin
              code_next = ple_pkg::ST_EMPTY;
            end else if (st.del_bad) begin
              code_next = ple_pkg::ST_RANGE;
            end else if (st.del_first) begin
              state_next = S_DEL;
            end else begin
              state_next = S_WALK;
            end
          end
          ple_pkg::REQ_SEARCH, ple_pkg::REQ_RD_FWD, ple_pkg::REQ_RD_BWD: begin
            if (st.empty) begin
              code_next = ple_pkg::ST_EMPTY;
            end else begin
              state_next = S_SCAN;
              if (back) begin
                cmd.adv_bwd      = 1'b1;
                cmd.idx_to_count = 1'b1;
              end
            end
          end
          default: begin
            state_next = S_EMIT;
          end
        endcase
      end
      S_WALK: begin
        cmd.adv_fwd = 1'b1;
        cmd.idx_inc = 1'b1;
        if (st.walk_last) begin
          state_next = (st.req == ple_pkg::REQ_DEL_AT) ? S_DEL : S_INS1;
        end
      end
      S_INS1: begin
        cmd.wr_ins1 = 1'b1;
        state_next  = S_INS2;
      end
      S_INS2: begin
        cmd.wr_ins2 = 1'b1;
        state_next  = S_EMIT;
      end
      S_DEL: begin
        cmd.wr_del = 1'b1;
        state_next = S_EMIT;
      end
      S_SCAN: begin
        if (st.req == ple_pkg::REQ_SEARCH) begin
          if (!(st.match && st.pend_valid && !st.out_free)) begin
            cmd.adv_fwd = 1'b1;
            cmd.idx_inc = 1'b1;
            if (st.match) begin
              cmd.pend_set = 1'b1;
              if (st.pend_valid) begin
                cmd.out_load   = 1'b1;
                cmd.out_sel    = ple_pkg::OSEL_PEND;
                cmd.out_status = ple_pkg::ST_OK;
              end
            end
            if (st.idx_is_count) state_next = S_SFIN;
          end
        end else if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_sel    = ple_pkg::OSEL_ELEM;
          cmd.out_status = ple_pkg::ST_OK;
          cmd.out_last   = scan_last;
          if (back) begin
            cmd.adv_bwd = 1'b1;
            cmd.idx_dec = 1'b1;
          end else begin
            cmd.adv_fwd = 1'b1;
            cmd.idx_inc = 1'b1;
          end
          if (scan_last) state_next = S_IDLE;
        end
      end
      S_SFIN: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          if (st.pend_valid) begin
            cmd.out_sel    = ple_pkg::OSEL_PEND;
            cmd.out_status = ple_pkg::ST_OK;
          end else begin
            cmd.out_sel    = ple_pkg::OSEL_RES;
            cmd.out_status = ple_pkg::ST_NOT_FOUND;
          end
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_sel    = ple_pkg::OSEL_RES;
          cmd.out_status = code;
          cmd.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ple_dpath.sv =====
module ple_dpath #(
  parameter int LIST_CAPACITY = 64,
  parameter int VALUE_BITS    = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  ple_pkg::req_t      req_data,
  input  ple_pkg::ctl_cmd_t  cmd,
  output ple_pkg::ctl_stat_t st,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output ple_pkg::rsp_t      rsp_data
);

  localparam int SW = $clog2(LIST_CAPACITY);
  localparam int CW = $clog2(LIST_CAPACITY + 1);
  localparam int EW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;
  localparam int DW = ple_pkg::DATA_W;

  logic [ple_pkg::REQ_W-1:0] req_q;
  logic [VALUE_BITS-1:0]     key, key_in;
  logic [ple_pkg::POS_W-1:0] pos_q;
  logic [CW-1:0]             count;
  logic [SW-1:0]             head, cur, cur_next, clr_idx, ns;
  logic [CW-1:0]             idx, pend_pos;
  logic                      pend_valid;
  logic [DW-1:0]             res_val, elem_out, key_out;
  logic [ple_pkg::POS_W-1:0] res_pos;

  logic [VALUE_BITS-1:0] val_q;
  logic [SW-1:0]         fwd_q, bwd_q, pool_q;

  logic                  val_we, fwd_we, bwd_we, pool_we;
  logic [SW-1:0]         fwd_wa, fwd_wd, bwd_wa, bwd_wd, pool_wa, pool_wd;

  logic [EW-1:0] count_x, pos_x, idx_x, pend_x, ins_p;
  logic          out_free, count_gt1;

  generate
    if (VALUE_BITS > DW) begin : g_wide
      assign key_in   = {{(VALUE_BITS - DW){req_data.item_value[DW-1]}}, req_data.item_value};
      assign elem_out = val_q[DW-1:0];
      assign key_out  = key[DW-1:0];
    end else if (VALUE_BITS == DW) begin : g_same
      assign key_in   = req_data.item_value;
      assign elem_out = val_q;
      assign key_out  = key;
    end else begin : g_narrow
      assign key_in   = req_data.item_value[VALUE_BITS-1:0];
      assign elem_out = {{(DW - VALUE_BITS){1'b0}}, val_q};
      assign key_out  = {{(DW - VALUE_BITS){1'b0}}, key};
    end
  endgenerate

  assign count_x   = EW'(count);
  assign pos_x     = EW'(pos_q);
  assign idx_x     = EW'(idx);
  assign pend_x    = EW'(pend_pos);
  assign ns        = pool_q;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign count_gt1 = count_x > EW'(1);

  always_comb begin
    case (req_q)
      ple_pkg::REQ_INS_HEAD: ins_p = EW'(1);
      ple_pkg::REQ_INS_TAIL: ins_p = count_x + EW'(1);
      default:               ins_p = pos_x;
    endcase
  end

  always_comb begin
    st.req          = req_q;
    st.clr_last     = (clr_idx == SW'(LIST_CAPACITY - 1));
    st.empty        = (count_x == '0);
    st.ins_bad      = (ins_p == '0) || (ins_p > count_x + EW'(1));
    st.ins_full     = (count_x >= EW'(LIST_CAPACITY));
    st.ins_to_head  = (ins_p == EW'(1));
    st.ins_at_end   = (ins_p > count_x);
    st.del_bad      = (pos_x == '0) || (pos_x > count_x);
    st.del_first    = (pos_x == EW'(1));
    st.walk_last    = (idx_x + EW'(1) == pos_x);
    st.idx_is_one   = (idx_x == EW'(1));
    st.idx_is_count = (idx_x == count_x);
    st.match        = (val_q == key);
    st.pend_valid   = pend_valid;
    st.out_free     = out_free;
  end

  always_comb begin
    cur_next = cur;
    if (cmd.load_head) begin
      cur_next = head;
    end else if (cmd.adv_fwd) begin
      cur_next = fwd_q;
    end else if (cmd.adv_bwd) begin
      cur_next = bwd_q;
    end
  end

  always_comb begin
    val_we  = cmd.wr_single || cmd.wr_ins1;
    fwd_we  = 1'b0;
    fwd_wa  = ns;
    fwd_wd  = ns;
    bwd_we  = 1'b0;
    bwd_wa  = ns;
    bwd_wd  = ns;
    pool_we = 1'b0;
    pool_wa = clr_idx;
    pool_wd = clr_idx;
    if (cmd.wr_single) begin
      fwd_we = 1'b1;
      bwd_we = 1'b1;
    end
    if (cmd.wr_ins1) begin
      fwd_we = 1'b1;
      fwd_wd = cur;
      bwd_we = 1'b1;
      bwd_wd = bwd_q;
    end
    if (cmd.wr_ins2) begin
      fwd_we = 1'b1;
      fwd_wa = bwd_q;
      bwd_we = 1'b1;
      bwd_wa = cur;
    end
    if (cmd.wr_del) begin
      fwd_we  = count_gt1;
      fwd_wa  = bwd_q;
      fwd_wd  = fwd_q;
      bwd_we  = count_gt1;
      bwd_wa  = fwd_q;
      bwd_wd  = bwd_q;
      pool_we = 1'b1;
      pool_wa = SW'(count - CW'(1));
      pool_wd = cur;
    end
    if (cmd.clear) begin
      pool_we = 1'b1;
    end
  end

  ple_ram #(.WIDTH(VALUE_BITS), .DEPTH(LIST_CAPACITY)) u_val (
    .clk   (clk),
    .we    (val_we),
    .waddr (ns),
    .wdata (key),
    .raddr (cur_next),
    .rdata (val_q)
  );

  ple_ram #(.WIDTH(SW), .DEPTH(LIST_CAPACITY)) u_fwd (
    .clk   (clk),
    .we    (fwd_we),
    .waddr (fwd_wa),
    .wdata (fwd_wd),
    .raddr (cur_next),
    .rdata (fwd_q)
  );

  ple_ram #(.WIDTH(SW), .DEPTH(LIST_CAPACITY)) u_bwd (
    .clk   (clk),
    .we    (bwd_we),
    .waddr (bwd_wa),
    .wdata (bwd_wd),
    .raddr (cur_next),
    .rdata (bwd_q)
  );

  ple_ram #(.WIDTH(SW), .DEPTH(LIST_CAPACITY)) u_pool (
    .clk   (clk),
    .we    (pool_we),
    .waddr (pool_wa),
    .wdata (pool_wd),
    .raddr (count[SW-1:0]),
    .rdata (pool_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      head       <= '0;
      clr_idx    <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
      req_q      <= ple_pkg::REQ_COUNT;
    end else begin
      if (cmd.clear) clr_idx <= clr_idx + SW'(1);
      if (cmd.take) begin
        req_q      <= req_data.req_type;
        pend_valid <= 1'b0;
      end
      if (cmd.pend_set) pend_valid <= 1'b1;
      if (cmd.wr_single || cmd.wr_ins2) begin
        count <= count + CW'(1);
      end else if (cmd.wr_del) begin
        count <= count - CW'(1);
      end
      if (cmd.wr_single || (cmd.wr_ins2 && st.ins_to_head)) begin
        head <= ns;
      end else if (cmd.wr_del && count_gt1 && st.del_first) begin
        head <= fwd_q;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (cmd.take) begin
      key     <= key_in;
      pos_q   <= req_data.list_position;
      res_val <= '0;
      res_pos <= '0;
    end
    if (cmd.wr_del) begin
      res_val <= elem_out;
      res_pos <= pos_q;
    end
    if (cmd.load_head) begin
      idx <= CW'(1);
    end else if (cmd.idx_to_count) begin
      idx <= count;
    end else if (cmd.idx_inc) begin
      idx <= idx + CW'(1);
    end else if (cmd.idx_dec) begin
      idx <= idx - CW'(1);
    end
    if (cmd.pend_set) pend_pos <= idx;
    if (cmd.out_load) begin
      rsp_data.status        <= cmd.out_status;
      rsp_data.element_total <= count_x[ple_pkg::POS_W-1:0];
      rsp_data.last_of_run   <= cmd.out_last;
      case (cmd.out_sel)
        ple_pkg::OSEL_ELEM: begin
          rsp_data.out_value    <= elem_out;
          rsp_data.out_position <= idx_x[ple_pkg::POS_W-1:0];
        end
        ple_pkg::OSEL_PEND: begin
          rsp_data.out_value    <= key_out;
          rsp_data.out_position <= pend_x[ple_pkg::POS_W-1:0];
        end
        default: begin
          rsp_data.out_value    <= res_val;
          rsp_data.out_position <= res_pos;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_x <= EW'(LIST_CAPACITY))
    else $error("element count above capacity");

  a_link_order: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_ins2 |-> $past(cmd.wr_ins1))
    else $error("second link write without the first");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      (count_x == EW'($past(count)) + EW'(1) || count_x + EW'(1) == EW'($past(count))))
    else $error("element count moved by more than one");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result register loaded while a stalled result waits");

endmodule

// ===== tb/positional_list_checker.sv =====
module positional_list_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  ple_pkg::req_t req_data,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  ple_pkg::rsp_t rsp_data,
  output int            fail_count,
  output int            pending_results,
  output int            live_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import ple_pkg::*;

  localparam int CAP = 64;

  logic signed [DATA_W-1:0] slot_val [CAP];
  int fwd [CAP];
  int bwd [CAP];
  int free_pool [CAP];
  int head;
  int count;
  rsp_t expected_q[$];

  assign pending_results = expected_q.size();
  assign live_count = count;

  function automatic rsp_t mk(logic [STAT_W-1:0] st, logic signed [DATA_W-1:0] v, int p,
                              logic last);
    rsp_t r;
    r.status = st;
    r.out_value = v;
    r.out_position = POS_W'(p);
    r.element_total = POS_W'(count);
    r.last_of_run = last;
    return r;
  endfunction

  function automatic int slot_at(int p);
    int s;
    s = head;
    for (int i = 1; i < p; i++) s = fwd[s];
    return s;
  endfunction

  task automatic predict_request(req_t rq);
    int p, s, a, b, ns, tgt, pr, n;
    logic signed [DATA_W-1:0] dv;
    n = 0;
    case (rq.req_type)
      REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_AT: begin
        p = (rq.req_type == REQ_INS_HEAD) ? 1 :
            (rq.req_type == REQ_INS_TAIL) ? count + 1 : int'(rq.list_position);
        if (p == 0 || p > count + 1) expected_q.push_back(mk(ST_RANGE, 0, 0, 1'b1));
        else if (count >= CAP) expected_q.push_back(mk(ST_FULL, 0, 0, 1'b1));
        else begin
          ns = free_pool[count];
          slot_val[ns] = rq.item_value;
          if (count == 0) begin
            fwd[ns] = ns;
            bwd[ns] = ns;
            head = ns;
          end else begin
            tgt = (p > count) ? head : slot_at(p);
            pr = bwd[tgt];
            fwd[pr] = ns;
            bwd[ns] = pr;
            fwd[ns] = tgt;
            bwd[tgt] = ns;
            if (p == 1) head = ns;
          end
          count++;
          expected_q.push_back(mk(ST_OK, 0, 0, 1'b1));
        end
      end
      REQ_DEL_AT: begin
        p = int'(rq.list_position);
        if (count == 0) expected_q.push_back(mk(ST_EMPTY, 0, 0, 1'b1));
        else if (p == 0 || p > count) expected_q.push_back(mk(ST_RANGE, 0, 0, 1'b1));
        else begin
          s = slot_at(p);
          dv = slot_val[s];
          if (count > 1) begin
            a = bwd[s];
            b = fwd[s];
            fwd[a] = b;
            bwd[b] = a;
            if (p == 1) head = b;
          end
          count--;
          free_pool[count] = s;
          expected_q.push_back(mk(ST_OK, dv, p, 1'b1));
        end
      end
      REQ_SEARCH: begin
        if (count == 0) expected_q.push_back(mk(ST_EMPTY, 0, 0, 1'b1));
        else begin
          s = head;
          for (int i = 1; i <= count; i++) begin
            if (slot_val[s] == rq.item_value) begin
              expected_q.push_back(mk(ST_OK, rq.item_value, i, 1'b0));
              n++;
            end
            s = fwd[s];
          end
          if (n == 0) expected_q.push_back(mk(ST_NOT_FOUND, 0, 0, 1'b1));
          else expected_q[$].last_of_run = 1'b1;
        end
      end
      REQ_RD_FWD, REQ_RD_BWD: begin
        if (count == 0) expected_q.push_back(mk(ST_EMPTY, 0, 0, 1'b1));
        else begin
          s = (rq.req_type == REQ_RD_BWD) ? bwd[head] : head;
          for (int i = 1; i <= count; i++) begin
            p = (rq.req_type == REQ_RD_FWD) ? i : count + 1 - i;
            expected_q.push_back(mk(ST_OK, slot_val[s], p, i == count));
            s = (rq.req_type == REQ_RD_FWD) ? fwd[s] : bwd[s];
          end
        end
      end
      default: expected_q.push_back(mk(ST_OK, 0, 0, 1'b1));
    endcase
  endtask

  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      for (int i = 0; i < CAP; i++) free_pool[i] = i;
      head = 0;
      count = 0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (req_valid && !req_stall) predict_request(req_data);
      if (rsp_valid && !rsp_stall) begin
        if (expected_q.size() == 0) begin
          $error("result with no expectation: %p", rsp_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e != rsp_data) begin
            fail_count <= fail_count + 1;
            if (e.status != rsp_data.status)
              $error("status exp %0d got %0d", e.status, rsp_data.status);
            if (e.out_value != rsp_data.out_value)
              $error("out_value exp %0d got %0d", e.out_value, rsp_data.out_value);
            if (e.out_position != rsp_data.out_position)
              $error("out_position exp %0d got %0d", e.out_position, rsp_data.out_position);
            if (e.element_total != rsp_data.element_total)
              $error("element_total exp %0d got %0d", e.element_total,
                     rsp_data.element_total);
            if (e.last_of_run != rsp_data.last_of_run)
              $error("last_of_run exp %0d got %0d", e.last_of_run, rsp_data.last_of_run);
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb_positional_list_engine.sv =====
module tb_positional_list_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import ple_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_data;
  int fail_count, pending_results, live_count;
  int idle_pct = 22;
  bit hold_rsp = 1'b0;
  int quiet_cycles = 0;
  logic signed [DATA_W-1:0] used_vals[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_list_engine u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
  );

  positional_list_checker u_chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
    .fail_count(fail_count), .pending_results(pending_results), .live_count(live_count)
  );

  always @(posedge clk) begin
    if (rst) rsp_stall <= 1'b0;
    else rsp_stall <= hold_rsp || ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("positional_list_engine verification failed");
      $finish;
    end
  end

  task automatic send_request(logic [REQ_W-1:0] rt, int v, int p);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    req_valid <= 1'b1;
    req_data <= '{req_type: rt, item_value: DATA_W'(v), list_position: POS_W'(p)};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    req_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_results != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    if (used_vals.size() != 0 && $urandom_range(2) == 0)
      return used_vals[$urandom_range(used_vals.size() - 1)];
    pick_value = $urandom_range(3) == 0 ? DATA_W'($urandom) : DATA_W'($urandom_range(7)) - 3;
    used_vals.push_back(pick_value);
  endfunction

  task automatic random_request();
    int roll, c;
    logic signed [DATA_W-1:0] v;
    roll = $urandom_range(99);
    c = live_count;
    v = pick_value();
    if (roll < 14) send_request(REQ_INS_HEAD, v, int'($urandom_range(127)));
    else if (roll < 28) send_request(REQ_INS_TAIL, v, int'($urandom_range(127)));
    else if (roll < 48) send_request(REQ_INS_AT, v,
        $urandom_range(9) == 0 ? int'($urandom_range(127)) : int'($urandom_range(c + 1, 1)));
    else if (roll < 66) send_request(REQ_DEL_AT, v,
        $urandom_range(9) == 0 ? int'($urandom_range(127)) :
                                 int'($urandom_range(c > 0 ? c : 1, 1)));
    else if (roll < 80) send_request(REQ_SEARCH, v, int'($urandom_range(127)));
    else if (roll < 88) send_request(REQ_RD_FWD, v, int'($urandom_range(127)));
    else if (roll < 95) send_request(REQ_RD_BWD, v, int'($urandom_range(127)));
    else send_request(REQ_COUNT, v, int'($urandom_range(127)));
    @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_request(REQ_DEL_AT, 0, 1);
    send_request(REQ_SEARCH, 5, 0);
    send_request(REQ_RD_FWD, 0, 0);
    send_request(REQ_RD_BWD, 0, 0);
    send_request(REQ_COUNT, 0, 0);
    send_request(REQ_INS_AT, 1, 2);
    send_request(REQ_INS_AT, 7, 1);
    send_request(REQ_INS_HEAD, 32'sh7fffffff, 127);
    send_request(REQ_INS_TAIL, 32'sh80000000, 0);
    send_request(REQ_INS_AT, 7, 2);
    send_request(REQ_INS_AT, -1, 0);
    send_request(REQ_INS_AT, -1, 127);
    send_request(REQ_SEARCH, 7, 0);
    send_request(REQ_SEARCH, 12345, 0);
    send_request(REQ_RD_FWD, 0, 0);
    send_request(REQ_RD_BWD, 0, 0);
    send_request(REQ_DEL_AT, 0, 0);
    send_request(REQ_DEL_AT, 0, 5);
    send_request(REQ_DEL_AT, 0, 4);
    send_request(REQ_DEL_AT, 0, 1);
    send_request(REQ_DEL_AT, 0, 2);
    send_request(REQ_DEL_AT, 0, 1);
    send_request(REQ_COUNT, 0, 0);
    drain();
    for (int i = 0; i < 66; i++) send_request(REQ_INS_TAIL, i % 5, 0);
    send_request(REQ_INS_AT, 9, 65);
    send_request(REQ_SEARCH, 2, 0);
    fork
      begin
        hold_rsp = 1'b1;
        repeat (300) @(posedge clk);
        hold_rsp = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_request(REQ_COUNT, 0, 0);
    join
    send_request(REQ_RD_BWD, 0, 0);
    drain();
    for (int i = 0; i < 60; i++) send_request(REQ_DEL_AT, 0, int'($urandom_range(64 - i, 1)));
    drain();
    for (int i = 0; i < 270; i++) begin
      idle_pct = (i >= 120 && i < 180) ? 0 : 22;
      if (live_count > 30) send_request(REQ_DEL_AT, 0, int'($urandom_range(live_count, 1)));
      else random_request();
      if (i == 200) drain();
    end
    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("positional_list_engine verification clean");
    else $display("positional_list_engine verification failed");
    $finish;
  end
endmodule
